// ===== design/mm3_pkg.sv =====
// shared types, constants and sequencer tables for the murmur3 x64 128-bit hash
`timescale 1ns / 1ps
`default_nettype none

package mm3_pkg;

	// mixing and finalizer constants
	localparam logic [63:0] MIX_C1 = 64'h87c3_7b91_1142_53d5;
	localparam logic [63:0] MIX_C2 = 64'h4cf5_ad43_2745_937f;
	localparam logic [63:0] ADD_H1 = 64'h0000_0000_52dc_e729;
	localparam logic [63:0] ADD_H2 = 64'h0000_0000_3849_5ab5;
	localparam logic [63:0] FIN_M1 = 64'hff51_afd7_ed55_8ccd;
	localparam logic [63:0] FIN_M2 = 64'hc4ce_b9fe_1a85_ec53;

	// bytes in one block
	localparam logic [4:0] BLOCK_BYTES = 5'd16;

	// last step index of each sequencer phase
	localparam logic [3:0] MIX_LAST  = 4'd11;
	localparam logic [3:0] BODY_LAST = 4'd3;
	localparam logic [3:0] FIN_LAST  = 4'd15;

	// phase of the shared 32x32 multiplier
	typedef enum logic [1:0] {
		MS_NONE,
		MS_P0,
		MS_P1,
		MS_P2
	} mstep_t;

	// multiplier operand source
	typedef enum logic [1:0] {
		SRC_K1,
		SRC_K2,
		SRC_H1,
		SRC_H2
	} src_t;

	// multiplier constant select
	typedef enum logic [1:0] {
		CST_C1,
		CST_C2,
		CST_F1,
		CST_F2
	} cst_t;

	// product writeback
	typedef enum logic [2:0] {
		WB_NONE,
		WB_K1_ROT,
		WB_K1,
		WB_K2_ROT,
		WB_K2,
		WB_H1_XS,
		WB_H2_XS
	} wb_t;

	// lane operations
	typedef enum logic [3:0] {
		LOP_NONE,
		LOP_H1_A,
		LOP_H1_B,
		LOP_H2_A,
		LOP_H2_B,
		LOP_TAIL,
		LOP_FIN_A,
		LOP_FIN_B,
		LOP_FIN_XS,
		LOP_FIN_C,
		LOP_OUT
	} lop_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_MIX,
		S_BODY,
		S_TAIL,
		S_FIN,
		S_OUT
	} state_t;

	// command from controller to datapath
	typedef struct packed {
		logic   load;
		logic   init;
		mstep_t mstep;
		src_t   src;
		cst_t   cst;
		wb_t    wb;
		lop_t   lop;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic last;
		logic full;
	} dp_status_t;

	function automatic logic [63:0] rotl64(input logic [63:0] v, input int s);
		return (v << s) | (v >> (64 - s));
	endfunction

	function automatic logic [63:0] xs33(input logic [63:0] v);
		return v ^ (v >> 33);
	endfunction

	function automatic logic [63:0] cst_value(input cst_t c);
		logic [63:0] r;
		unique case (c)
			CST_C1: r = MIX_C1;
			CST_C2: r = MIX_C2;
			CST_F1: r = FIN_M1;
			CST_F2: r = FIN_M2;
			default: r = MIX_C1;
		endcase
		return r;
	endfunction

	function automatic dp_cmd_t mul_cmd(input mstep_t ms, input src_t s, input cst_t c,
	                                    input wb_t w);
		dp_cmd_t r;
		r = '0;
		r.mstep = ms;
		r.src = s;
		r.cst = c;
		r.wb = w;
		return r;
	endfunction

	function automatic dp_cmd_t lop_cmd(input lop_t l);
		dp_cmd_t r;
		r = '0;
		r.lop = l;
		return r;
	endfunction

	// k1 * C1, rotl 31, * C2, then k2 * C2, rotl 33, * C1
	function automatic dp_cmd_t mix_cmd(input logic [3:0] step);
		dp_cmd_t r;
		unique case (step)
			4'd0:  r = mul_cmd(MS_P0, SRC_K1, CST_C1, WB_K1_ROT);
			4'd1:  r = mul_cmd(MS_P1, SRC_K1, CST_C1, WB_K1_ROT);
			4'd2:  r = mul_cmd(MS_P2, SRC_K1, CST_C1, WB_K1_ROT);
			4'd3:  r = mul_cmd(MS_P0, SRC_K1, CST_C2, WB_K1);
			4'd4:  r = mul_cmd(MS_P1, SRC_K1, CST_C2, WB_K1);
			4'd5:  r = mul_cmd(MS_P2, SRC_K1, CST_C2, WB_K1);
			4'd6:  r = mul_cmd(MS_P0, SRC_K2, CST_C2, WB_K2_ROT);
			4'd7:  r = mul_cmd(MS_P1, SRC_K2, CST_C2, WB_K2_ROT);
			4'd8:  r = mul_cmd(MS_P2, SRC_K2, CST_C2, WB_K2_ROT);
			4'd9:  r = mul_cmd(MS_P0, SRC_K2, CST_C1, WB_K2);
			4'd10: r = mul_cmd(MS_P1, SRC_K2, CST_C1, WB_K2);
			4'd11: r = mul_cmd(MS_P2, SRC_K2, CST_C1, WB_K2);
			default: r = lop_cmd(LOP_NONE);
		endcase
		return r;
	endfunction

	// lane recurrence of a full block
	function automatic dp_cmd_t body_cmd(input logic [1:0] step);
		dp_cmd_t r;
		unique case (step)
			2'd0: r = lop_cmd(LOP_H1_A);
			2'd1: r = lop_cmd(LOP_H1_B);
			2'd2: r = lop_cmd(LOP_H2_A);
			2'd3: r = lop_cmd(LOP_H2_B);
			default: r = lop_cmd(LOP_NONE);
		endcase
		return r;
	endfunction

	// length fold, lane adds and both 64-bit finalizers
	function automatic dp_cmd_t fin_cmd(input logic [3:0] step);
		dp_cmd_t r;
		unique case (step)
			4'd0:  r = lop_cmd(LOP_FIN_A);
			4'd1:  r = lop_cmd(LOP_FIN_B);
			4'd2:  r = lop_cmd(LOP_FIN_XS);
			4'd3:  r = mul_cmd(MS_P0, SRC_H1, CST_F1, WB_H1_XS);
			4'd4:  r = mul_cmd(MS_P1, SRC_H1, CST_F1, WB_H1_XS);
			4'd5:  r = mul_cmd(MS_P2, SRC_H1, CST_F1, WB_H1_XS);
			4'd6:  r = mul_cmd(MS_P0, SRC_H1, CST_F2, WB_H1_XS);
			4'd7:  r = mul_cmd(MS_P1, SRC_H1, CST_F2, WB_H1_XS);
			4'd8:  r = mul_cmd(MS_P2, SRC_H1, CST_F2, WB_H1_XS);
			4'd9:  r = mul_cmd(MS_P0, SRC_H2, CST_F1, WB_H2_XS);
			4'd10: r = mul_cmd(MS_P1, SRC_H2, CST_F1, WB_H2_XS);
			4'd11: r = mul_cmd(MS_P2, SRC_H2, CST_F1, WB_H2_XS);
			4'd12: r = mul_cmd(MS_P0, SRC_H2, CST_F2, WB_H2_XS);
			4'd13: r = mul_cmd(MS_P1, SRC_H2, CST_F2, WB_H2_XS);
			4'd14: r = mul_cmd(MS_P2, SRC_H2, CST_F2, WB_H2_XS);
			4'd15: r = lop_cmd(LOP_FIN_C);
			default: r = lop_cmd(LOP_NONE);
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/murmur3_128_hash.sv =====
// An accepted block is mixed and, if full, run through the lane recurrence; a non-last block
// then returns the sequencer to idle, and no new block is accepted before that. A last block
// goes through the tail step if partial or empty, then the finalizer, then raises hash_valid
// once the previous hash is taken. One shared 32x32 multiplier builds each 64-bit product
// from partial products in turn: 4 products per block and 4 more for the finalizer, beside the serial lane steps.
// Reset (arst_n low) clears the seed to zero, closes any open message and drops the result.
`timescale 1ns / 1ps
`default_nettype none

module murmur3_128_hash (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        seed_we,
	input  wire logic [31:0] seed,
	input  wire logic        blk_valid,
	output logic             blk_ready,
	input  wire logic [63:0] block_low,
	input  wire logic [63:0] block_high,
	input  wire logic [4:0]  valid_bytes,
	input  wire logic        last,
	output logic             hash_valid,
	input  wire logic        hash_ready,
	output logic [63:0]      hash_low,
	output logic [63:0]      hash_high
);

	mm3_pkg::dp_cmd_t    cmd;
	mm3_pkg::dp_status_t status;

	// sequencer
	mm3_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.blk_valid  (blk_valid),
		.blk_ready  (blk_ready),
		.hash_valid (hash_valid),
		.hash_ready (hash_ready),
		.status     (status),
		.cmd        (cmd)
	);

	// lanes and arithmetic
	mm3_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.seed_we     (seed_we),
		.seed        (seed),
		.block_low   (block_low),
		.block_high  (block_high),
		.valid_bytes (valid_bytes),
		.last        (last),
		.cmd         (cmd),
		.status      (status),
		.hash_low    (hash_low),
		.hash_high   (hash_high)
	);

endmodule

`default_nettype wire

// ===== design/mm3_datapath.sv =====
// datapath: seed, lanes, byte count, shared multiplier and result registers
`timescale 1ns / 1ps
`default_nettype none

module mm3_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                seed_we,
	input  wire logic [31:0]         seed,
	input  wire logic [63:0]         block_low,
	input  wire logic [63:0]         block_high,
	input  wire logic [4:0]          valid_bytes,
	input  wire logic                last,
	input  wire mm3_pkg::dp_cmd_t    cmd,
	output mm3_pkg::dp_status_t      status,
	output logic [63:0]              hash_low,
	output logic [63:0]              hash_high
);

	logic [31:0] seed_q;
	logic [63:0] h1_q, h2_q, k1_q, k2_q, len_q, acc_q;
	logic        last_q, full_q;
	logic [63:0] hash_low_q, hash_high_q;

	logic [4:0]  cnt_sat, eff;
	logic [63:0] lo_m, hi_m;
	logic [63:0] src_val, cst_val;
	logic [31:0] mul_x, mul_y;
	logic [63:0] mul_p, acc_sum;
	logic [63:0] h1a, h1b, h2a, h2b, x1, x2, h1_plus;

	// effective byte count and byte masking
	always_comb begin
		cnt_sat = (valid_bytes > mm3_pkg::BLOCK_BYTES) ? mm3_pkg::BLOCK_BYTES : valid_bytes;
		eff = last ? cnt_sat : mm3_pkg::BLOCK_BYTES;
		for (int i = 0; i < 8; i++) begin
			lo_m[8*i +: 8] = (5'(i) < eff) ? block_low[8*i +: 8] : 8'h00;
			hi_m[8*i +: 8] = (5'(i + 8) < eff) ? block_high[8*i +: 8] : 8'h00;
		end
	end

	// multiplier operand select
	always_comb begin
		case (cmd.src)
			mm3_pkg::SRC_K1: src_val = k1_q;
			mm3_pkg::SRC_K2: src_val = k2_q;
			mm3_pkg::SRC_H1: src_val = h1_q;
			mm3_pkg::SRC_H2: src_val = h2_q;
			default:         src_val = k1_q;
		endcase
		cst_val = mm3_pkg::cst_value(cmd.cst);
	end

	// one 32x32 partial product per cycle, low 64 bits of the full product
	always_comb begin
		case (cmd.mstep)
			mm3_pkg::MS_P0: begin
				mul_x = src_val[31:0];
				mul_y = cst_val[31:0];
			end
			mm3_pkg::MS_P1: begin
				mul_x = src_val[31:0];
				mul_y = cst_val[63:32];
			end
			default: begin
				mul_x = src_val[63:32];
				mul_y = cst_val[31:0];
			end
		endcase
		mul_p = {32'h0, mul_x} * {32'h0, mul_y};
		acc_sum = acc_q + {mul_p[31:0], 32'h0};
	end

	// lane arithmetic
	always_comb begin
		h1a = mm3_pkg::rotl64(h1_q ^ k1_q, 27) + h2_q;
		h1b = h1_q + {h1_q[61:0], 2'b00} + mm3_pkg::ADD_H1;
		h2a = mm3_pkg::rotl64(h2_q ^ k2_q, 31) + h1_q;
		h2b = h2_q + {h2_q[61:0], 2'b00} + mm3_pkg::ADD_H2;
		x1 = h1_q ^ len_q;
		x2 = h2_q ^ len_q;
		h1_plus = h1_q + h2_q;
	end

	// seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 32'h0;
		end else if (seed_we) begin
			seed_q <= seed;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			k1_q <= lo_m;
			k2_q <= hi_m;
			last_q <= last;
			full_q <= (eff == mm3_pkg::BLOCK_BYTES);
			len_q <= (cmd.init ? 64'h0 : len_q) + {59'h0, eff};
			if (cmd.init) begin
				h1_q <= {32'h0, seed_q};
				h2_q <= {32'h0, seed_q};
			end
		end

		case (cmd.mstep)
			mm3_pkg::MS_P0: acc_q <= mul_p;
			mm3_pkg::MS_P1: acc_q <= acc_sum;
			default: ;
		endcase

		if (cmd.mstep == mm3_pkg::MS_P2) begin
			case (cmd.wb)
				mm3_pkg::WB_K1_ROT: k1_q <= mm3_pkg::rotl64(acc_sum, 31);
				mm3_pkg::WB_K1:     k1_q <= acc_sum;
				mm3_pkg::WB_K2_ROT: k2_q <= mm3_pkg::rotl64(acc_sum, 33);
				mm3_pkg::WB_K2:     k2_q <= acc_sum;
				mm3_pkg::WB_H1_XS:  h1_q <= mm3_pkg::xs33(acc_sum);
				mm3_pkg::WB_H2_XS:  h2_q <= mm3_pkg::xs33(acc_sum);
				default: ;
			endcase
		end

		case (cmd.lop)
			mm3_pkg::LOP_H1_A: h1_q <= h1a;
			mm3_pkg::LOP_H1_B: h1_q <= h1b;
			mm3_pkg::LOP_H2_A: h2_q <= h2a;
			mm3_pkg::LOP_H2_B: h2_q <= h2b;
			mm3_pkg::LOP_TAIL: begin
				// mixed zero blocks are zero, so masked lanes xor in nothing
				h1_q <= h1_q ^ k1_q;
				h2_q <= h2_q ^ k2_q;
			end
			mm3_pkg::LOP_FIN_A: begin
				h1_q <= x1 + x2;
				h2_q <= x2;
			end
			mm3_pkg::LOP_FIN_B: h2_q <= h1_plus;
			mm3_pkg::LOP_FIN_XS: begin
				h1_q <= mm3_pkg::xs33(h1_q);
				h2_q <= mm3_pkg::xs33(h2_q);
			end
			mm3_pkg::LOP_FIN_C: h1_q <= h1_plus;
			mm3_pkg::LOP_OUT: begin
				hash_low_q <= h1_q;
				hash_high_q <= h1_plus;
			end
			default: ;
		endcase
	end

	assign status.last = last_q;
	assign status.full = full_q;
	assign hash_low = hash_low_q;
	assign hash_high = hash_high_q;

endmodule

`default_nettype wire

// ===== design/mm3_ctrl.sv =====
// controller: handshakes and step sequencing of the datapath
`timescale 1ns / 1ps
`default_nettype none

module mm3_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 blk_valid,
	output logic                      blk_ready,
	output logic                      hash_valid,
	input  wire logic                 hash_ready,
	input  wire mm3_pkg::dp_status_t  status,
	output mm3_pkg::dp_cmd_t          cmd
);

	mm3_pkg::state_t state_q, state_d;
	logic [3:0] step_q, step_d;
	logic       open_q, open_d;
	logic       out_valid_q, out_valid_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mm3_pkg::S_IDLE;
			step_q <= 4'd0;
			open_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
			open_q <= open_d;
			out_valid_q <= out_valid_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		step_d = step_q;
		open_d = open_q;
		out_valid_d = out_valid_q;
		cmd = mm3_pkg::lop_cmd(mm3_pkg::LOP_NONE);
		blk_ready = 1'b0;

		// result transaction taken
		if (out_valid_q && hash_ready) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			mm3_pkg::S_IDLE: begin
				blk_ready = 1'b1;
				if (blk_valid) begin
					cmd.load = 1'b1;
					cmd.init = !open_q;
					open_d = 1'b1;
					step_d = 4'd0;
					state_d = mm3_pkg::S_MIX;
				end
			end
			mm3_pkg::S_MIX: begin
				cmd = mm3_pkg::mix_cmd(step_q);
				if (step_q == mm3_pkg::MIX_LAST) begin
					step_d = 4'd0;
					state_d = status.full ? mm3_pkg::S_BODY : mm3_pkg::S_TAIL;
				end else begin
					step_d = step_q + 4'd1;
				end
			end
			mm3_pkg::S_BODY: begin
				cmd = mm3_pkg::body_cmd(step_q[1:0]);
				if (step_q == mm3_pkg::BODY_LAST) begin
					step_d = 4'd0;
					if (status.last) begin
						open_d = 1'b0;
						state_d = mm3_pkg::S_FIN;
					end else begin
						state_d = mm3_pkg::S_IDLE;
					end
				end else begin
					step_d = step_q + 4'd1;
				end
			end
			mm3_pkg::S_TAIL: begin
				cmd = mm3_pkg::lop_cmd(mm3_pkg::LOP_TAIL);
				open_d = 1'b0;
				step_d = 4'd0;
				state_d = mm3_pkg::S_FIN;
			end
			mm3_pkg::S_FIN: begin
				cmd = mm3_pkg::fin_cmd(step_q);
				if (step_q == mm3_pkg::FIN_LAST) begin
					step_d = 4'd0;
					state_d = mm3_pkg::S_OUT;
				end else begin
					step_d = step_q + 4'd1;
				end
			end
			mm3_pkg::S_OUT: begin
				// load the output register once the previous result is gone
				if (!out_valid_q || hash_ready) begin
					cmd = mm3_pkg::lop_cmd(mm3_pkg::LOP_OUT);
					out_valid_d = 1'b1;
					state_d = mm3_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mm3_pkg::S_IDLE;
			end
		endcase
	end

	assign hash_valid = out_valid_q;

endmodule

`default_nettype wire
